// ===== sv/cyclic_sequencing_checker_macros.svh =====
// ----------------------------------------------------------------------------
// Cyclic sequencing checker assertion macros
// Shared forms for the concurrent checks of the checker block.
// ----------------------------------------------------------------------------
`ifndef CYCLIC_SEQUENCING_CHECKER_MACROS_SVH
`define CYCLIC_SEQUENCING_CHECKER_MACROS_SVH

// Check a property on every rising clock edge outside of reset.
`define CSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define CSC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// Cyclic sequencing checker package
// Widths, constants and arithmetic helpers shared by the checker files.
// ----------------------------------------------------------------------------
package csc_pkg;

  // Largest group order the sum datapath and the bitmap are sized for.
  localparam int MAX_MODULUS = 64;

  // Fixed field widths.
  localparam int MOD_W   = 7;
  localparam int ELEM_W  = 6;
  localparam int PSUM_W  = 6;
  localparam int COUNT_W = 48;

  // Derived widths.
  localparam int SUM_W  = $clog2(MAX_MODULUS);
  localparam int POS_W  = $clog2(MAX_MODULUS);
  localparam int AMOD_W = $clog2(MAX_MODULUS + 1);
  localparam int ACC_W  = ((SUM_W > ELEM_W) ? SUM_W : ELEM_W) + 1;
  localparam int RED_W  = ACC_W + AMOD_W;

  localparam logic [MOD_W-1:0]   MODULUS_RESET = MOD_W'(64);
  localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;

  // Clamp the register value to the supported range 2..MAX_MODULUS.
  function automatic logic [AMOD_W-1:0] clamp_modulus(input logic [MOD_W-1:0] value);
    logic [MOD_W+AMOD_W-1:0] wide;
    wide = (MOD_W + AMOD_W)'(value);
    if (wide < (MOD_W + AMOD_W)'(2)) begin
      return AMOD_W'(2);
    end else if (wide > (MOD_W + AMOD_W)'(MAX_MODULUS)) begin
      return AMOD_W'(MAX_MODULUS);
    end
    return wide[AMOD_W-1:0];
  endfunction

  // Reduce a narrow sum modulo m (m >= 2) by restoring compare and subtract,
  // one shifted copy of m per step.
  function automatic logic [SUM_W-1:0] mod_reduce(input logic [ACC_W-1:0]  value,
                                                  input logic [AMOD_W-1:0] m);
    logic [RED_W-1:0] rem;
    logic [RED_W-1:0] step;
    rem = RED_W'(value);
    for (int k = ACC_W - 2; k >= 0; k--) begin
      step = RED_W'(m) << k;
      if (rem >= step) begin
        rem = rem - step;
      end
    end
    return rem[SUM_W-1:0];
  endfunction

endpackage

// ===== sv/csc_if.sv =====
// ----------------------------------------------------------------------------
// Cyclic sequencing checker channels
// Valid/ready channels for the element stream and the result stream.
// ----------------------------------------------------------------------------
interface csc_elem_if import csc_pkg::*; (input logic clk);
  logic              valid;
  logic              ready;
  logic [ELEM_W-1:0] element;

  modport source (output valid, output element, input ready);
  modport sink   (input valid, input element, output ready);
endinterface

interface csc_result_if import csc_pkg::*; (input logic clk);
  logic               valid;
  logic               ready;
  logic [PSUM_W-1:0]  partial_sum;
  logic               still_good;
  logic               ordering_done;
  logic [COUNT_W-1:0] good_count;

  modport source (output valid, output partial_sum, output still_good,
                  output ordering_done, output good_count, input ready);
  modport sink   (input valid, input partial_sum, input still_good,
                  input ordering_done, input good_count, output ready);
endinterface

// ===== sv/cyclic_sequencing_checker.sv =====
// ----------------------------------------------------------------------------
// Cyclic sequencing checker
// Checks candidate orderings of the nonzero residues modulo n, one element
// per cycle while the result stream is not stalled, and counts the orderings
// whose partial sums are all distinct and nonzero.
//
// Usage:
//   elements : valid/ready stream of elements, modulus-1 of them per ordering.
//   results  : one item per element: running sum, verdict so far, end of
//              ordering flag and the saturating count of good orderings.
//   modulus_we / modulus_wdata : write the group order; write only while no
//              item is in flight. Values below 2 act as 2, values above the
//              supported maximum act as the maximum.
// From element accept to result valid, the element lands in the input
// register at the accept edge and moves on to the result register on advance.
// Throughput is 1 item per cycle while results are taken: the modular add,
// bitmap test and set and count update form one combinational step on the
// ordering state. A stalled receiver holds the result register; the input
// register then fills and ready drops until the result is taken.
// Reset clears the ordering state, the count and both valid bits, and loads
// the modulus with 64.
// ----------------------------------------------------------------------------
`include "cyclic_sequencing_checker_macros.svh"

module cyclic_sequencing_checker import csc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               modulus_we,
  input  logic [MOD_W-1:0]   modulus_wdata,
  csc_elem_if.sink           elements,
  csc_result_if.source       results
);

  // Configuration register.
  logic [MOD_W-1:0]  modulus;
  logic [AMOD_W-1:0] active_mod;

  // Input register stage.
  logic              in_valid;
  logic [ELEM_W-1:0] in_element;
  logic              advance;

  // Ordering state.
  logic [SUM_W-1:0]       running_sum;
  logic [MAX_MODULUS-1:0] seen_sums;
  logic [POS_W-1:0]       position;
  logic                   failed;
  logic [COUNT_W-1:0]     good_total;

  logic [SUM_W-1:0]       running_sum_next;
  logic [MAX_MODULUS-1:0] seen_sums_next;
  logic [POS_W-1:0]       position_next;
  logic                   failed_next;
  logic [COUNT_W-1:0]     good_total_next;
  logic                   done;

  // Result register.
  logic               out_valid;
  logic [PSUM_W-1:0]  out_partial_sum;
  logic               out_still_good;
  logic               out_ordering_done;
  logic [COUNT_W-1:0] out_good_count;

  // Hold the modulus until the next write.
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MODULUS_RESET;
    end else if (modulus_we) begin
      modulus <= modulus_wdata;
    end
  end

  assign active_mod = clamp_modulus(modulus);

  // Advance the input stage whenever the result register is free or drains.
  assign advance        = in_valid && (!out_valid || results.ready);
  assign elements.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (elements.ready) begin
      in_valid <= elements.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (elements.valid && elements.ready) begin
      in_element <= elements.element;
    end
  end

  // One step of the check: add, reduce, test the bitmap, decide the end, update the count.
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic             bad;
    sum = mod_reduce(ACC_W'(running_sum) + ACC_W'(in_element), active_mod);
    // Fail on an element outside 1..m-1, a zero sum or a repeated sum.
    bad = (in_element == '0)
       || (AMOD_W'(in_element) >= active_mod)
       || (sum == '0)
       || seen_sums[sum];
    failed_next = failed || bad;
    // The ordering ends once position has reached or passed m-2.
    done = AMOD_W'(position) >= (active_mod - AMOD_W'(2));

    good_total_next = good_total;
    if (done && !failed_next && (good_total != COUNT_MAX)) begin
      good_total_next = good_total + COUNT_W'(1);
    end

    seen_sums_next       = seen_sums;
    seen_sums_next[sum]  = 1'b1;
    running_sum_next     = sum;
    position_next        = position + POS_W'(1);
  end

  // Update the ordering state; clear it at the end of each ordering.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      seen_sums   <= '0;
      position    <= '0;
      failed      <= 1'b0;
      good_total  <= '0;
    end else if (advance) begin
      good_total <= good_total_next;
      if (done) begin
        running_sum <= '0;
        seen_sums   <= '0;
        position    <= '0;
        failed      <= 1'b0;
      end else begin
        running_sum <= running_sum_next;
        seen_sums   <= seen_sums_next;
        position    <= position_next;
        failed      <= failed_next;
      end
    end
  end

  // Result register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_partial_sum   <= PSUM_W'(running_sum_next);
      out_still_good    <= !failed_next;
      out_ordering_done <= done;
      out_good_count    <= good_total_next;
    end
  end

  assign results.valid         = out_valid;
  assign results.partial_sum   = out_partial_sum;
  assign results.still_good    = out_still_good;
  assign results.ordering_done = out_ordering_done;
  assign results.good_count    = out_good_count;

  // Checks.
  `CSC_ASSERT_ALWAYS(a_reset_clears_results, rst |=> !out_valid, "result valid after reset")
  `CSC_ASSERT(a_done_clears_state, (advance && done) |=> (position == '0 && seen_sums == '0 && running_sum == '0 && !failed), "ordering state not cleared at end")
  `CSC_ASSERT(a_count_monotonic, advance |=> (good_total >= $past(good_total)), "good count decreased")
  `CSC_ASSERT(a_bitmap_tracks_position, (advance && !done && !failed_next) |=> ($countones(seen_sums) == int'(position)), "bitmap population differs from position")

endmodule
